### design/aswe_pkg.sv
// Package: shared constants, types and control structures of the arrangement swap evaluator.
package aswe_pkg;

	localparam int MAX_VARS  = 64;
	localparam int NUM_NODES = 64;
	localparam int VAR_W     = $clog2(NUM_NODES);
	localparam int POS_W     = $clog2(MAX_VARS);
	localparam int CNT_W     = $clog2(MAX_VARS) + 1;
	localparam int COST_W    = 22;
	localparam int ACC_W     = 18;
	localparam int TOT_W     = 24;
	localparam int SUM_W     = TOT_W + 1;
	localparam int DSQ_W     = 2 * POS_W;
	localparam int TERM_W    = POS_W + 3;
	localparam int OP_W      = 3;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	typedef logic [VAR_W-1:0]     var_t;
	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [NUM_NODES-1:0] row_t;

	typedef enum logic [OP_W-1:0] {
		OP_WR_BIT    = 3'd0,
		OP_WR_ORDER  = 3'd1,
		OP_RECOMPUTE = 3'd2,
		OP_SWAP      = 3'd3,
		OP_READ      = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_BIT_WR,
		CM_SCAN_SETUP,
		CM_SCAN,
		CM_SWAP_EVAL,
		CM_DRAIN
	} cell_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROW_RD,
		ST_ROW_WR,
		ST_RC_SETUP,
		ST_SCAN,
		ST_SW_SETUP,
		ST_SW_EVAL,
		ST_DRAIN,
		ST_MUL,
		ST_APPLY,
		ST_RC_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		cell_mode_t         mode;
		cnt_t               n;
		logic [DSQ_W-1:0]   dsq;
		pos_t               s1;
		pos_t               s2;
		var_t               v1;
		var_t               v2;
		var_t               bit_var;
		var_t               bit_idx;
		logic               bit_val;
		logic               ld_a_en;
		pos_t               ld_a_pos;
		var_t               ld_a_var;
		row_t               ld_a_row;
		logic               ld_b_en;
		pos_t               ld_b_pos;
		var_t               ld_b_var;
		row_t               ld_b_row;
	} cell_ctl_t;

endpackage

### design/aswe_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface aswe_req_if;
	logic                      valid;
	logic                      ready;
	logic [aswe_pkg::OP_W-1:0] opcode;
	aswe_pkg::pos_t            index_a;
	aswe_pkg::var_t            index_b;
	logic                      bit_value;

	modport source (output valid, opcode, index_a, index_b, bit_value, input ready);
	modport sink   (input valid, opcode, index_a, index_b, bit_value, output ready);
endinterface

interface aswe_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [aswe_pkg::COST_W-1:0] cost;
	logic                        accepted;
	aswe_pkg::var_t              read_value;

	modport source (output valid, cost, accepted, read_value, input ready);
	modport sink   (input valid, cost, accepted, read_value, output ready);
endinterface

### design/arrangement_swap_evaluator_core.sv
// Top level: control sequencer, row memory and the chain of position cells.
// Sequence: writes read the row, then write it; reads and unused opcodes go straight to done;
// a rejected swap goes from setup to done; a swap proposal runs setup, evaluate, drain, multiply,
// apply, done; recompute runs setup, the distance shifts, drain, finish, done.
// Throughput: one item in flight; the sequencer returns to idle once the result is loaded into the output register.
// Reset clears the influence rows (via valid bits), the cost, and sets used_count to 64.
module arrangement_swap_evaluator_core (
	input  logic                    clk,
	input  logic                    arst_n,
	aswe_req_if.sink                req,
	aswe_rsp_if.source              rsp,
	input  logic                    cfg_wr_en,
	input  logic [aswe_pkg::CNT_W-1:0] cfg_wr_data
);
	// Architectural and sequencing registers
	aswe_pkg::state_t                  state_q, state_d;
	aswe_pkg::opcode_t                 op_q;
	aswe_pkg::pos_t                    a_q;
	aswe_pkg::var_t                    b_q;
	logic                              bit_q;
	aswe_pkg::cnt_t                    used_q;
	aswe_pkg::cnt_t                    cnt_q;
	logic [aswe_pkg::DSQ_W-1:0]        dsq_q;
	logic signed [aswe_pkg::TOT_W-1:0] total_q;
	logic signed [aswe_pkg::TOT_W-1:0] prod_q;
	aswe_pkg::var_t                    v1_q, v2_q;
	logic                              flag_q;
	logic [aswe_pkg::COST_W-1:0]       cost_q;

	// Output register
	logic                              out_valid_q;
	logic [aswe_pkg::COST_W-1:0]       out_cost_q;
	logic                              out_acc_q;
	aswe_pkg::var_t                    out_rd_q;

	// Cell chain wiring
	aswe_pkg::cell_ctl_t               ctl;
	aswe_pkg::var_t                    vid_w    [aswe_pkg::MAX_VARS];
	aswe_pkg::row_t                    row_w    [aswe_pkg::MAX_VARS];
	aswe_pkg::var_t                    tgt_w    [aswe_pkg::MAX_VARS];
	logic                              tok_w    [aswe_pkg::MAX_VARS];
	logic signed [aswe_pkg::ACC_W-1:0] acc_w    [aswe_pkg::MAX_VARS];
	aswe_pkg::var_t                    nb_vid_w [aswe_pkg::MAX_VARS];
	aswe_pkg::var_t                    nb_tgt_w [aswe_pkg::MAX_VARS];
	logic                              nb_tok_w [aswe_pkg::MAX_VARS];
	logic signed [aswe_pkg::ACC_W-1:0] nb_acc_w [aswe_pkg::MAX_VARS];

	// Row memory
	logic                              mem_we;
	aswe_pkg::var_t                    mem_raddr;
	aswe_pkg::row_t                    mem_rdata;
	aswe_pkg::row_t                    row_new;

	// Datapath helpers
	aswe_pkg::cnt_t                    n_eff;
	logic                              reject;
	logic                              req_fire;
	logic                              out_load;
	logic                              scan_last;
	logic                              drain_last;
	logic signed [aswe_pkg::POS_W:0]   pos_diff;
	logic signed [aswe_pkg::TOT_W+aswe_pkg::POS_W:0] prod_full;
	logic signed [aswe_pkg::SUM_W-1:0] cost_sum;
	logic [aswe_pkg::COST_W-1:0]       cost_new;
	logic [aswe_pkg::COST_W-1:0]       rc_cost;

	// Effective count: register value limited to the number of cells
	assign n_eff = (used_q > aswe_pkg::CNT_W'(aswe_pkg::MAX_VARS))
		? aswe_pkg::CNT_W'(aswe_pkg::MAX_VARS) : used_q;

	assign reject = (a_q == b_q) || ({1'b0, a_q} >= n_eff) || ({1'b0, b_q} >= n_eff);

	assign req_fire   = req.valid && req.ready;
	assign out_load   = (state_q == aswe_pkg::ST_DONE) && (!out_valid_q || rsp.ready);
	assign scan_last  = cnt_q == aswe_pkg::CNT_W'(aswe_pkg::MAX_VARS - 1);
	assign drain_last = cnt_q == aswe_pkg::CNT_W'(aswe_pkg::MAX_VARS - 1);

	// Swap delta is (s1 - s2) times the drained sum of weighted position terms
	assign pos_diff  = $signed({1'b0, a_q}) - $signed({1'b0, b_q});
	assign prod_full = pos_diff * total_q;

	// Clamp the updated cost into [0, COST_MAX]
	always_comb begin
		cost_sum = $signed({{(aswe_pkg::SUM_W - aswe_pkg::COST_W){1'b0}}, cost_q})
			+ $signed({prod_q[aswe_pkg::TOT_W-1], prod_q});
		if (cost_sum < 0) begin
			cost_new = '0;
		end else if (cost_sum > $signed({{(aswe_pkg::SUM_W - aswe_pkg::COST_W){1'b0}},
				aswe_pkg::COST_MAX})) begin
			cost_new = aswe_pkg::COST_MAX;
		end else begin
			cost_new = cost_sum[aswe_pkg::COST_W-1:0];
		end
		if (total_q > $signed({{(aswe_pkg::TOT_W - aswe_pkg::COST_W){1'b0}},
				aswe_pkg::COST_MAX})) begin
			rc_cost = aswe_pkg::COST_MAX;
		end else begin
			rc_cost = total_q[aswe_pkg::COST_W-1:0];
		end
	end

	// Read the row of the source variable for a bit write, of the new variable for an order write
	assign mem_raddr = (op_q == aswe_pkg::OP_WR_ORDER) ? b_q : a_q;

	always_comb begin
		row_new         = mem_rdata;
		row_new[b_q]    = bit_q;
	end

	aswe_row_mem u_row_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (a_q),
		.wdata  (row_new),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	// Next state and per-state cell commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		ctl.mode = aswe_pkg::CM_HOLD;
		ctl.n    = n_eff;
		ctl.dsq  = dsq_q;
		ctl.s1   = a_q;
		ctl.s2   = b_q;
		ctl.v1   = v1_q;
		ctl.v2   = v2_q;
		mem_we   = 1'b0;
		req.ready = state_q == aswe_pkg::ST_IDLE;
		case (state_q)
			aswe_pkg::ST_IDLE: begin
				if (req.valid) begin
					case (aswe_pkg::opcode_t'(req.opcode))
						aswe_pkg::OP_WR_BIT:    state_d = aswe_pkg::ST_ROW_RD;
						aswe_pkg::OP_WR_ORDER:  state_d = aswe_pkg::ST_ROW_RD;
						aswe_pkg::OP_RECOMPUTE: state_d = aswe_pkg::ST_RC_SETUP;
						aswe_pkg::OP_SWAP:      state_d = aswe_pkg::ST_SW_SETUP;
						default:                state_d = aswe_pkg::ST_DONE;
					endcase
				end
			end
			aswe_pkg::ST_ROW_RD: begin
				state_d = aswe_pkg::ST_ROW_WR;
			end
			aswe_pkg::ST_ROW_WR: begin
				if (op_q == aswe_pkg::OP_WR_BIT) begin
					// Update the master row and every cell that holds this variable
					mem_we      = 1'b1;
					ctl.mode    = aswe_pkg::CM_BIT_WR;
					ctl.bit_var = a_q;
					ctl.bit_idx = b_q;
					ctl.bit_val = bit_q;
				end else begin
					ctl.ld_a_en  = 1'b1;
					ctl.ld_a_pos = a_q;
					ctl.ld_a_var = b_q;
					ctl.ld_a_row = mem_rdata;
				end
				state_d = aswe_pkg::ST_DONE;
			end
			aswe_pkg::ST_RC_SETUP: begin
				ctl.mode = aswe_pkg::CM_SCAN_SETUP;
				state_d  = aswe_pkg::ST_SCAN;
			end
			aswe_pkg::ST_SCAN: begin
				ctl.mode = aswe_pkg::CM_SCAN;
				if (scan_last) begin
					state_d = aswe_pkg::ST_DRAIN;
				end
			end
			aswe_pkg::ST_SW_SETUP: begin
				state_d = reject ? aswe_pkg::ST_DONE : aswe_pkg::ST_SW_EVAL;
			end
			aswe_pkg::ST_SW_EVAL: begin
				ctl.mode = aswe_pkg::CM_SWAP_EVAL;
				state_d  = aswe_pkg::ST_DRAIN;
			end
			aswe_pkg::ST_DRAIN: begin
				ctl.mode = aswe_pkg::CM_DRAIN;
				if (drain_last) begin
					state_d = (op_q == aswe_pkg::OP_SWAP) ? aswe_pkg::ST_MUL
						: aswe_pkg::ST_RC_FIN;
				end
			end
			aswe_pkg::ST_MUL: begin
				state_d = aswe_pkg::ST_APPLY;
			end
			aswe_pkg::ST_APPLY: begin
				// Exchange the two cells only when the cost strictly falls
				if (prod_q < 0) begin
					ctl.ld_a_en  = 1'b1;
					ctl.ld_a_pos = a_q;
					ctl.ld_a_var = v2_q;
					ctl.ld_a_row = row_w[b_q];
					ctl.ld_b_en  = 1'b1;
					ctl.ld_b_pos = b_q;
					ctl.ld_b_var = v1_q;
					ctl.ld_b_row = row_w[a_q];
				end
				state_d = aswe_pkg::ST_DONE;
			end
			aswe_pkg::ST_RC_FIN: begin
				state_d = aswe_pkg::ST_DONE;
			end
			aswe_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = aswe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aswe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aswe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= aswe_pkg::CNT_W'(aswe_pkg::MAX_VARS);
			cost_q      <= '0;
			flag_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				used_q <= cfg_wr_data;
			end
			if (req_fire) begin
				flag_q <= 1'b0;
			end
			case (state_q)
				aswe_pkg::ST_RC_SETUP: begin
					cnt_q <= aswe_pkg::CNT_W'(1);
				end
				aswe_pkg::ST_SCAN: begin
					cnt_q <= scan_last ? '0 : cnt_q + aswe_pkg::CNT_W'(1);
				end
				aswe_pkg::ST_SW_EVAL: begin
					cnt_q <= '0;
				end
				aswe_pkg::ST_DRAIN: begin
					cnt_q <= cnt_q + aswe_pkg::CNT_W'(1);
				end
				aswe_pkg::ST_APPLY: begin
					if (prod_q < 0) begin
						flag_q <= 1'b1;
						cost_q <= cost_new;
					end
				end
				aswe_pkg::ST_RC_FIN: begin
					cost_q <= rc_cost;
				end
				default: begin
				end
			endcase
			// Hold the result until the sink takes it
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q  <= aswe_pkg::opcode_t'(req.opcode);
			a_q   <= req.index_a;
			b_q   <= req.index_b;
			bit_q <= req.bit_value;
		end
		case (state_q)
			aswe_pkg::ST_RC_SETUP: begin
				dsq_q   <= aswe_pkg::DSQ_W'(1);
				total_q <= '0;
			end
			aswe_pkg::ST_SCAN: begin
				// Advance d^2 to (d+1)^2
				dsq_q <= dsq_q + aswe_pkg::DSQ_W'({cnt_q, 1'b1});
			end
			aswe_pkg::ST_SW_SETUP: begin
				v1_q    <= vid_w[a_q];
				v2_q    <= vid_w[b_q];
				total_q <= '0;
			end
			aswe_pkg::ST_DRAIN: begin
				total_q <= total_q + {{(aswe_pkg::TOT_W - aswe_pkg::ACC_W){acc_w[0][aswe_pkg::ACC_W-1]}},
					acc_w[0]};
			end
			aswe_pkg::ST_MUL: begin
				prod_q <= prod_full[aswe_pkg::TOT_W-1:0];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_cost_q <= cost_q;
			out_acc_q  <= flag_q;
			out_rd_q   <= (op_q == aswe_pkg::OP_READ) ? vid_w[a_q] : '0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.cost       = out_cost_q;
	assign rsp.accepted   = out_acc_q;
	assign rsp.read_value = out_rd_q;

	// Chain of position cells; each hands its target and partial sum to the cell below
	for (genvar k = 0; k < aswe_pkg::MAX_VARS; k++) begin : g_cell
		if (k == aswe_pkg::MAX_VARS - 1) begin : g_end
			assign nb_vid_w[k] = '0;
			assign nb_tgt_w[k] = '0;
			assign nb_tok_w[k] = 1'b0;
			assign nb_acc_w[k] = '0;
		end else begin : g_mid
			assign nb_vid_w[k] = vid_w[k+1];
			assign nb_tgt_w[k] = tgt_w[k+1];
			assign nb_tok_w[k] = tok_w[k+1];
			assign nb_acc_w[k] = acc_w[k+1];
		end

		aswe_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.pos       (aswe_pkg::POS_W'(k)),
			.nb_vid    (nb_vid_w[k]),
			.nb_tgt    (nb_tgt_w[k]),
			.nb_tgt_ok (nb_tok_w[k]),
			.nb_acc    (nb_acc_w[k]),
			.vid       (vid_w[k]),
			.row       (row_w[k]),
			.tgt       (tgt_w[k]),
			.tgt_ok    (tok_w[k]),
			.acc       (acc_w[k])
		);
	end

	// An accepted transaction always leaves the idle state
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q != aswe_pkg::ST_IDLE)
		else $error("request accepted but sequencer stayed idle");

	// An applied swap never raises the cost
	a_swap_cost: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aswe_pkg::ST_APPLY && prod_q < 0) |=> cost_q <= $past(cost_q))
		else $error("applied swap raised the cost");

	// The applied flag comes only from a swap proposal
	a_flag_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(flag_q && state_q != aswe_pkg::ST_IDLE) |-> op_q == aswe_pkg::OP_SWAP)
		else $error("applied flag set outside a swap");
endmodule

### design/aswe_row_mem.sv
// Influence row memory: one row per variable, rows read as zero until first written.
module aswe_row_mem (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           we,
	input  aswe_pkg::var_t waddr,
	input  aswe_pkg::row_t wdata,
	input  aswe_pkg::var_t raddr,
	output aswe_pkg::row_t rdata
);
	aswe_pkg::row_t                       mem_q [aswe_pkg::NUM_NODES];
	logic [aswe_pkg::NUM_NODES-1:0]       valid_q;
	aswe_pkg::row_t                       rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= valid_q[raddr] ? mem_q[raddr] : '0;
	end

	assign rdata = rdata_q;
endmodule

### design/aswe_cell.sv
// Position cell: holds one ordering entry with its influence row and a partial cost sum.
module aswe_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  aswe_pkg::cell_ctl_t                ctl,
	input  aswe_pkg::pos_t                     pos,
	input  aswe_pkg::var_t                     nb_vid,
	input  aswe_pkg::var_t                     nb_tgt,
	input  logic                               nb_tgt_ok,
	input  logic signed [aswe_pkg::ACC_W-1:0]  nb_acc,
	output aswe_pkg::var_t                     vid,
	output aswe_pkg::row_t                     row,
	output aswe_pkg::var_t                     tgt,
	output logic                               tgt_ok,
	output logic signed [aswe_pkg::ACC_W-1:0]  acc
);
	aswe_pkg::var_t                     vid_q;
	aswe_pkg::row_t                     row_q;
	aswe_pkg::var_t                     tgt_q;
	logic                               tgt_ok_q;
	logic signed [aswe_pkg::ACC_W-1:0]  acc_q;

	logic                               in_use;
	logic                               next_ok;
	logic                               hit;
	logic signed [aswe_pkg::TERM_W-1:0] term;
	logic signed [aswe_pkg::ACC_W-1:0]  term_x;
	logic signed [aswe_pkg::ACC_W-1:0]  sw_val;

	always_comb begin
		in_use  = {1'b0, pos} < ctl.n;
		next_ok = ({1'b0, pos} + aswe_pkg::CNT_W'(1)) < ctl.n;
		hit     = in_use && tgt_ok_q && row_q[tgt_q];
		term    = $signed({2'b00, pos, 1'b0}) - $signed({3'b000, ctl.s1})
			- $signed({3'b000, ctl.s2});
		term_x  = {{(aswe_pkg::ACC_W - aswe_pkg::TERM_W){term[aswe_pkg::TERM_W-1]}}, term};
		sw_val  = '0;
		if (in_use && (pos != ctl.s1) && (pos != ctl.s2)) begin
			if (row_q[ctl.v1] && !row_q[ctl.v2]) begin
				sw_val = term_x;
			end else if (row_q[ctl.v2] && !row_q[ctl.v1]) begin
				sw_val = -term_x;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.mode)
			aswe_pkg::CM_BIT_WR: begin
				if (vid_q == ctl.bit_var) begin
					row_q[ctl.bit_idx] <= ctl.bit_val;
				end
			end
			aswe_pkg::CM_SCAN_SETUP: begin
				tgt_q <= nb_vid;
			end
			aswe_pkg::CM_SCAN: begin
				tgt_q <= nb_tgt;
			end
			default: begin
			end
		endcase
		if (ctl.ld_a_en && (pos == ctl.ld_a_pos)) begin
			vid_q <= ctl.ld_a_var;
			row_q <= ctl.ld_a_row;
		end
		if (ctl.ld_b_en && (pos == ctl.ld_b_pos)) begin
			vid_q <= ctl.ld_b_var;
			row_q <= ctl.ld_b_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_ok_q <= 1'b0;
			acc_q    <= '0;
		end else begin
			case (ctl.mode)
				aswe_pkg::CM_SCAN_SETUP: begin
					tgt_ok_q <= next_ok;
					acc_q    <= '0;
				end
				aswe_pkg::CM_SCAN: begin
					tgt_ok_q <= nb_tgt_ok;
					if (hit) begin
						acc_q <= acc_q + $signed({1'b0, ctl.dsq});
					end
				end
				aswe_pkg::CM_SWAP_EVAL: begin
					acc_q <= sw_val;
				end
				aswe_pkg::CM_DRAIN: begin
					acc_q <= nb_acc;
				end
				default: begin
				end
			endcase
		end
	end

	assign vid    = vid_q;
	assign row    = row_q;
	assign tgt    = tgt_q;
	assign tgt_ok = tgt_ok_q;
	assign acc    = acc_q;
endmodule

### tb/tb_aswe_if.sv
// Testbench side of the channels: the request and response interfaces come from design/aswe_if.sv.
`timescale 1ns / 1ps

### tb/tb_arrangement_swap_evaluator_core.sv
// Testbench top: drives random and directed arrangement operations and checks every response.
`timescale 1ns / 1ps
module tb_arrangement_swap_evaluator_core;
	import aswe_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0] op;
		pos_t            a;
		var_t            b;
		logic            bitv;
	} op_item_t;

	typedef struct packed {
		logic        cfg;      // register write marker; the driver does not send an item that has it set
		logic [6:0]  cfg_val;
		logic        hold;     // wait until every response has come before this item
		op_item_t    it;
	} pend_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              acc;
		var_t              rd;
	} rsp_t;

	localparam int SETTLE = 200;
	localparam int LIMIT  = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CNT_W-1:0] cfg_wr_data = '0;

	aswe_req_if req();
	aswe_rsp_if rsp();

	arrangement_swap_evaluator_core uut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	row_t        infl_rows [NUM_NODES];
	var_t        arrangement [MAX_VARS];
	logic [COST_W-1:0] arr_cost;
	int          used_n;

	pend_t       pending_ops[$];
	rsp_t        expected_rsp[$];
	int          mismatches = 0;
	int          cycle_cnt = 0;
	bit          quiet = 1'b0;      // no-idle stretch
	bit          hold_drv = 1'b0;

	function automatic int eff_count();
		return used_n > MAX_VARS ? MAX_VARS : used_n;
	endfunction

	function automatic logic [COST_W-1:0] arrangement_cost();
		longint sum;
		int n;
		sum = 0;
		n = eff_count();
		for (int i = 0; i + 1 < n; i++)
			for (int j = i + 1; j < n; j++)
				if (infl_rows[arrangement[i]][arrangement[j]])
					sum += (j - i) * (j - i);
		return sum > COST_MAX ? COST_MAX : sum[COST_W-1:0];
	endfunction

	function automatic rsp_t predict_rsp(op_item_t it);
		rsp_t r;
		longint delta, c;
		int n;
		int s1, s2;
		var_t v1, v2;
		r.acc = 1'b0;
		r.rd = '0;
		s1 = int'(it.a);
		s2 = int'(it.b);
		case (it.op)
			OP_WR_BIT: infl_rows[it.a][it.b] = it.bitv;
			OP_WR_ORDER: arrangement[it.a] = it.b;
			OP_RECOMPUTE: arr_cost = arrangement_cost();
			OP_READ: r.rd = arrangement[it.a];
			OP_SWAP: begin
				n = eff_count();
				if (s1 != s2 && s1 < n && s2 < n) begin
					v1 = arrangement[it.a];
					v2 = arrangement[it.b];
					delta = 0;
					for (int i = 0; i < n; i++) begin
						if (i == s1 || i == s2)
							continue;
						if (infl_rows[arrangement[i]][v1])
							delta += (i - s2) * (i - s2) - (i - s1) * (i - s1);
						if (infl_rows[arrangement[i]][v2])
							delta += (i - s1) * (i - s1) - (i - s2) * (i - s2);
					end
					if (delta < 0) begin
						arrangement[it.a] = v2;
						arrangement[it.b] = v1;
						c = longint'(arr_cost) + delta;
						arr_cost = c < 0 ? '0 : (c > COST_MAX ? COST_MAX : c[COST_W-1:0]);
						r.acc = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.cost = arr_cost;
		return r;
	endfunction

	// driver: advance through pending items, predict on each accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_rsp = {expected_rsp, predict_rsp({req.opcode, req.index_a,
					req.index_b, req.bit_value})};
			if (!req.valid || req.ready) begin
				if (pending_ops.size() > 0 && !pending_ops[0].cfg && !hold_drv
						&& (quiet || $urandom_range(99) >= 20)
						&& !(pending_ops[0].hold && (expected_rsp.size() > 0
						|| (req.valid && req.ready)))) begin
					req.valid <= 1'b1;
					req.opcode <= pending_ops[0].it.op;
					req.index_a <= pending_ops[0].it.a;
					req.index_b <= pending_ops[0].it.b;
					req.bit_value <= pending_ops[0].it.bitv;
					void'(pending_ops.pop_front());
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each response transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response cost=%0d acc=%0b rd=%0d",
							rsp.cost, rsp.accepted, rsp.read_value);
				end else begin
					if (rsp.cost !== expected_rsp[0].cost || rsp.accepted !== expected_rsp[0].acc
							|| rsp.read_value !== expected_rsp[0].rd) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp cost=%0d acc=%0b rd=%0d, got cost=%0d acc=%0b rd=%0d",
								expected_rsp[0].cost, expected_rsp[0].acc, expected_rsp[0].rd,
								rsp.cost, rsp.accepted, rsp.read_value);
					end
					void'(expected_rsp.pop_front());
				end
			end
			rsp.ready <= quiet || $urandom_range(99) >= 20;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic op_item_t mk(int op, int a, int b, int v);
		op_item_t it;
		it.op = OP_W'(op);
		it.a = pos_t'(a);
		it.b = var_t'(b);
		it.bitv = v[0];
		return it;
	endfunction

	task automatic queue_op(op_item_t it, bit hold = 1'b0);
		pend_t p;
		p = '0;
		p.hold = hold;
		p.it = it;
		pending_ops = {pending_ops, p};
	endtask

	// wait for the driver to empty its queue and every response to arrive, then settle
	task automatic drain_all();
		wait (pending_ops.size() == 0);
		@(posedge clk);
		while (req.valid || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_used(int val);
		drain_all();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CNT_W'(val);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		used_n = val;
	endtask

	// load a full arrangement so no unwritten entry is ever read
	task automatic fill_arrangement(bit ident);
		for (int p = 0; p < MAX_VARS; p++)
			queue_op(mk(OP_WR_ORDER, p, ident ? p : $urandom_range(63), 0));
	endtask

	// random phase with a swap-heavy mix, including out-of-range swaps and unused opcodes
	task automatic random_phase(int cnt);
		int k;
		int r;
		int n;
		n = eff_count();
		for (k = 0; k < cnt; k++) begin
			r = $urandom_range(99);
			if (r < 25)
				queue_op(mk(OP_WR_BIT, $urandom_range(63), $urandom_range(63), $urandom_range(1)));
			else if (r < 33)
				queue_op(mk(OP_WR_ORDER, $urandom_range(63), $urandom_range(63), $urandom_range(1)));
			else if (r < 40)
				queue_op(mk(OP_RECOMPUTE, $urandom_range(63), $urandom_range(63), $urandom_range(1)));
			else if (r < 75)
				queue_op(mk(OP_SWAP, $urandom_range(n - 1), $urandom_range(n - 1),
					$urandom_range(1)));
			else if (r < 80)
				queue_op(mk(OP_SWAP, $urandom_range(63), $urandom_range(63), $urandom_range(1)));
			else if (r < 93)
				queue_op(mk(OP_READ, $urandom_range(63), $urandom_range(63), $urandom_range(1)));
			else
				queue_op(mk($urandom_range(7, 5), $urandom_range(63), $urandom_range(63),
					$urandom_range(1)));
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.opcode = '0;
		req.index_a = '0;
		req.index_b = '0;
		req.bit_value = 1'b0;
		rsp.ready = 1'b0;
		for (int i = 0; i < NUM_NODES; i++)
			infl_rows[i] = '0;
		for (int i = 0; i < MAX_VARS; i++)
			arrangement[i] = '0;
		arr_cost = '0;
		used_n = 64;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every opcode, special cases
		fill_arrangement(1'b1);
		queue_op(mk(OP_WR_BIT, 0, 63, 1));
		queue_op(mk(OP_WR_BIT, 63, 0, 1));
		queue_op(mk(OP_WR_BIT, 5, 5, 1));
		queue_op(mk(OP_WR_BIT, 5, 5, 0));
		queue_op(mk(OP_RECOMPUTE, 0, 0, 0));
		queue_op(mk(OP_SWAP, 0, 63, 0));
		queue_op(mk(OP_SWAP, 7, 7, 1));
		queue_op(mk(OP_SWAP, 63, 1, 0));
		queue_op(mk(OP_READ, 0, 0, 0));
		queue_op(mk(OP_READ, 63, 63, 1));
		queue_op(mk(5, 63, 63, 1));
		queue_op(mk(7, 0, 0, 0));
		queue_op(mk(6, 1, 2, 1), 1'b1);
		drain_all();
		// dense corner of the matrix with a short ordering, then the full one
		write_used(2);
		for (int a = 0; a < 8; a++)
			for (int b = 0; b < 8; b++)
				queue_op(mk(OP_WR_BIT, a, b, 1));
		queue_op(mk(OP_RECOMPUTE, 0, 0, 0));
		queue_op(mk(OP_SWAP, 0, 1, 0));
		queue_op(mk(OP_SWAP, 0, 2, 0));
		write_used(64);
		queue_op(mk(OP_RECOMPUTE, 0, 0, 0));
		queue_op(mk(OP_SWAP, 3, 60, 0));
		quiet = 1'b1;
		random_phase(150);  // sparsify while quiet
		drain_all();
		quiet = 1'b0;

		// random phases across register settings
		write_used(1);
		queue_op(mk(OP_RECOMPUTE, 0, 0, 0));
		queue_op(mk(OP_SWAP, 0, 1, 0));
		write_used(0);
		queue_op(mk(OP_RECOMPUTE, 0, 0, 0));
		write_used(127);
		random_phase(150);
		write_used(3);
		random_phase(150);
		write_used(16);
		fill_arrangement(1'b0);
		random_phase(150);
		write_used(64);
		queue_op(mk(OP_RECOMPUTE, 0, 0, 0), 1'b1);
		random_phase(150);
		drain_all();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
